/* rtl/core/homogeneous_point_transform_core_macros.svh */
// Assertion macros for the homogeneous point transform.
// Included by the port checker; no other dependencies.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_CORE_MACROS_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define HPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Immediate-style invariant checked on every rising clock edge outside reset
`define HPT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

`endif

/* rtl/core/hpt_pkg.sv */
// Package for the homogeneous point transform: widths, reset values, stage types.
// No dependencies.
package hpt_pkg;

  localparam int unsigned NumRegs  = 8;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned SumW     = 50;   // cut row sum, magnitude below 2^49
  localparam int unsigned DivSteps = 32;   // quotient bits left after overflow test

  localparam logic [NumRegs-1:0][63:0] RegReset = '{
    64'h0001_0000_0000_0000,  // row3_zw
    64'h0000_0000_0000_0000,  // row3_xy
    64'h0000_0000_0001_0000,  // row2_zw
    64'h0000_0000_0000_0000,  // row2_xy
    64'h0000_0000_0000_0000,  // row1_zw
    64'h0001_0000_0000_0000,  // row1_xy
    64'h0000_0000_0000_0000,  // row0_zw
    64'h0000_0000_0001_0000   // row0_xy
  };

  localparam logic [31:0] SatPos = 32'h7FFF_FFFF;
  localparam logic [31:0] SatNeg = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } clamp_t;

  // Product stage: four columns of three row products
  typedef struct packed {
    logic                          raw;
    logic [3:0][2:0][63:0]         prod;
  } mul_stage_t;

  typedef struct packed {
    logic                          raw;
    logic [3:0][SumW-1:0]          v;
  } sum_stage_t;

  // One step of the three divider lanes, with side results carried along
  typedef struct packed {
    logic                          wz;
    logic [2:0]                    use_div;
    logic [2:0]                    neg;
    logic [2:0]                    ovf;
    logic [2:0]                    csat;
    logic [2:0][31:0]              cval;
    logic                          wsat;
    logic [31:0]                   wval;
    logic [SumW-1:0]               nw;
    logic [2:0][SumW-1:0]          rem;
    logic [2:0][31:0]              src;
    logic [2:0][31:0]              q;
  } div_stage_t;

  typedef struct packed {
    logic [3:0][31:0] val;
    logic             wz;
    logic             sat;
  } out_stage_t;

  // Saturate a signed cut sum to 32 bits
  function automatic clamp_t clamp_sum(input logic signed [SumW-1:0] v);
    clamp_t r;
    if (v > $signed({{(SumW-32){1'b0}}, SatPos})) begin
      r.val = SatPos;
      r.sat = 1'b1;
    end else if (v < $signed({{(SumW-32){1'b1}}, SatNeg})) begin
      r.val = SatNeg;
      r.sat = 1'b1;
    end else begin
      r.val = v[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

/* rtl/core/homogeneous_point_transform_core.sv */
// Top level of the homogeneous point transform: matrix registers and the full pipeline.
// Depends on hpt_pkg.
//
// Transforms a Q16.16 point (w = 1) by a 4x4 matrix and optionally divides x, y, z by w.
// One point enters and a result leaves per cycle unless the output stalls; the stages are:
// one multiply stage (twelve 32x32 products), one summing stage, one set-up stage,
// 32 stages of a one-bit-per-stage restoring divider (three lanes) and the output
// register. Each stage holds its item while the next is full, so only empty slots
// are filled during a downstream stall. The matrix must be written only when idle.
module homogeneous_point_transform_core
  import hpt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [IdxW-1:0]      cfg_index_i,
  input  logic [63:0]          cfg_data_i,
  // point input
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 opcode_i,
  input  logic signed [31:0]   in_x_i,
  input  logic signed [31:0]   in_y_i,
  input  logic signed [31:0]   in_z_i,
  // result output
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [31:0]   out_x_o,
  output logic signed [31:0]   out_y_o,
  output logic signed [31:0]   out_z_o,
  output logic signed [31:0]   out_w_o,
  output logic                 w_zero_o,
  output logic                 saturated_o
);

  localparam int unsigned NumStg = DivSteps + 4;
  localparam int unsigned StgDiv0 = 2;
  localparam int unsigned StgOut  = NumStg - 1;

  logic [NumRegs-1:0][63:0] cfg_q;
  logic [NumStg-1:0]        vld_q;
  logic [NumStg-1:0]        rdy;

  mul_stage_t                 mul_q, mul_d;
  sum_stage_t                 sum_q, sum_d;
  div_stage_t [DivSteps:0]    div_q;
  div_stage_t                 div_d [DivSteps+1];
  out_stage_t                 out_q, out_d;

  // Matrix registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= RegReset;
    end else if (cfg_valid_i) begin
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // Per-stage hold: a stage takes a new item when empty or when its item moves on
  always_comb begin
    rdy[StgOut] = !vld_q[StgOut] || out_ready_i;
    for (int k = StgOut - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStg; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage 0: row products
  always_comb begin
    logic signed [31:0] pt [3];
    logic signed [31:0] e;
    pt[0] = in_x_i;
    pt[1] = in_y_i;
    pt[2] = in_z_i;
    mul_d.raw = opcode_i;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 3; r++) begin
        e = (c % 2 == 1) ? cfg_q[r*2 + c/2][63:32] : cfg_q[r*2 + c/2][31:0];
        mul_d.prod[c][r] = 64'(pt[r] * e);
      end
    end
  end

  // Stage 1: exact row sums cut to Q16.16 (floor)
  always_comb begin
    logic signed [65:0] acc;
    logic signed [31:0] t;
    sum_d.raw = mul_q.raw;
    for (int c = 0; c < 4; c++) begin
      t   = (c % 2 == 1) ? cfg_q[6 + c/2][63:32] : cfg_q[6 + c/2][31:0];
      acc = $signed({{2{mul_q.prod[c][0][63]}}, mul_q.prod[c][0]})
          + $signed({{2{mul_q.prod[c][1][63]}}, mul_q.prod[c][1]})
          + $signed({{2{mul_q.prod[c][2][63]}}, mul_q.prod[c][2]})
          + $signed({{18{t[31]}}, t, 16'h0000});
      sum_d.v[c] = acc[65:16];
    end
  end

  // Stage 2: signs, magnitudes, overflow test and clamped undivided values
  always_comb begin
    logic signed [SumW-1:0] w;
    logic signed [SumW-1:0] v;
    logic [SumW-1:0]        nv;
    clamp_t                 cl;
    w  = sum_q.v[3];
    cl = clamp_sum(w);
    div_d[0]      = '0;
    div_d[0].wz   = (w == '0);
    div_d[0].wval = cl.val;
    div_d[0].wsat = cl.sat;
    div_d[0].nw   = w[SumW-1] ? SumW'(-w) : w;
    for (int l = 0; l < 3; l++) begin
      v  = sum_q.v[l];
      cl = clamp_sum(v);
      nv = v[SumW-1] ? SumW'(-v) : v;
      div_d[0].cval[l]    = cl.val;
      div_d[0].csat[l]    = cl.sat;
      div_d[0].use_div[l] = !sum_q.raw && (w != '0);
      div_d[0].neg[l]     = v[SumW-1] ^ w[SumW-1];
      div_d[0].ovf[l]     = {16'h0000, nv[SumW-1:16]} >= div_d[0].nw;
      div_d[0].rem[l]     = {16'h0000, nv[SumW-1:16]};
      div_d[0].src[l]     = {nv[15:0], 16'h0000};
      div_d[0].q[l]       = '0;
    end
  end

  // Divider steps: one quotient bit per lane per stage
  for (genvar s = 1; s <= DivSteps; s++) begin : g_div
    always_comb begin
      logic [SumW:0] t;
      logic          ge;
      div_d[s] = div_q[s-1];
      for (int l = 0; l < 3; l++) begin
        t  = {div_q[s-1].rem[l], div_q[s-1].src[l][31]};
        ge = t >= {1'b0, div_q[s-1].nw};
        div_d[s].rem[l] = ge ? SumW'(t - {1'b0, div_q[s-1].nw}) : t[SumW-1:0];
        div_d[s].src[l] = {div_q[s-1].src[l][30:0], 1'b0};
        div_d[s].q[l]   = {div_q[s-1].q[l][30:0], ge};
      end
    end
  end

  // Final stage: sign and saturation of the quotients, or the clamped undivided values
  always_comb begin
    div_stage_t d;
    logic       sat;
    d   = div_q[DivSteps];
    sat = d.wsat;
    out_d.val[3] = d.wval;
    out_d.wz     = d.wz;
    for (int l = 0; l < 3; l++) begin
      if (!d.use_div[l]) begin
        out_d.val[l] = d.cval[l];
        sat          = sat | d.csat[l];
      end else if (d.ovf[l]) begin
        out_d.val[l] = d.neg[l] ? SatNeg : SatPos;
        sat          = 1'b1;
      end else if (d.neg[l]) begin
        if (d.q[l] > SatNeg) begin
          out_d.val[l] = SatNeg;
          sat          = 1'b1;
        end else begin
          out_d.val[l] = 32'(-d.q[l]);
        end
      end else begin
        if (d.q[l] > SatPos) begin
          out_d.val[l] = SatPos;
          sat          = 1'b1;
        end else begin
          out_d.val[l] = d.q[l];
        end
      end
    end
    out_d.sat = sat;
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      mul_q <= mul_d;
    end
    if (rdy[1]) begin
      sum_q <= sum_d;
    end
    for (int s = 0; s <= DivSteps; s++) begin
      if (rdy[StgDiv0 + s]) begin
        div_q[s] <= div_d[s];
      end
    end
    if (rdy[StgOut]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q[StgOut];
  assign out_x_o     = out_q.val[0];
  assign out_y_o     = out_q.val[1];
  assign out_z_o     = out_q.val[2];
  assign out_w_o     = out_q.val[3];
  assign w_zero_o    = out_q.wz;
  assign saturated_o = out_q.sat;

endmodule

/* rtl/core/hpt_checker.sv */
// Port checker for the homogeneous point transform, bound to the top level.
// Depends on homogeneous_point_transform_core_macros.svh.
`include "homogeneous_point_transform_core_macros.svh"

module hpt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] out_w_o,
  input logic        w_zero_o
);

  // A waiting result stays offered
  `HPT_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped")

  // Input is only refused when the pipe is full up to a stalled output
  `HPT_ASSERT(a_back_pressure, !in_ready_o |-> out_valid_o && !out_ready_i, "stall without cause")

  // Zero flag matches the reported w
  `HPT_ASSERT(a_w_zero, out_valid_o |-> (w_zero_o == (out_w_o == 32'h0)), "w_zero mismatch")

endmodule

bind homogeneous_point_transform_core hpt_checker u_hpt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_w_o     (out_w_o),
  .w_zero_o    (w_zero_o)
);
